// ----- rtl/core/scta_pkg.sv -----
`timescale 1ns / 1ps

package scta_pkg;

    // Default sizing, handed down from the top level
    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int MAX_READ_DEF    = 64;

    // Field widths
    localparam int CODE_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int COUNT_W = 7;

    // Command codes
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [CODE_W-1:0]  scan_code;
        logic [COUNT_W-1:0] read_count;
    } t_in_word;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              char_valid;
        logic              last;
        logic              overflow_seen;
    } t_out_word;

    // Memory port strobes from the controller to the ring store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // Set-1 QWERTZ translation; zero means the code gives no character
    function automatic logic [CHAR_W-1:0] scta_translate(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        unique case (code)
            8'h1C: ch = 7'h0A; // newline
            8'h39: ch = 7'h20; // space
            8'h0E: ch = 7'h0D; // carriage return
            8'hB4: ch = 7'h2E; // '.'
            8'hB5: ch = 7'h2F; // '/'
            8'h29: ch = 7'h30; // '0'
            8'h02: ch = 7'h31;
            8'h03: ch = 7'h32;
            8'h04: ch = 7'h33;
            8'h05: ch = 7'h34;
            8'h06: ch = 7'h35;
            8'h07: ch = 7'h36;
            8'h08: ch = 7'h37;
            8'h09: ch = 7'h38;
            8'h0A: ch = 7'h39;
            8'h10: ch = 7'h71; // q
            8'h11: ch = 7'h77; // w
            8'h12: ch = 7'h65; // e
            8'h13: ch = 7'h72; // r
            8'h14: ch = 7'h74; // t
            8'h15: ch = 7'h7A; // z
            8'h16: ch = 7'h75; // u
            8'h17: ch = 7'h69; // i
            8'h18: ch = 7'h6F; // o
            8'h19: ch = 7'h70; // p
            8'h1E: ch = 7'h61; // a
            8'h1F: ch = 7'h73; // s
            8'h20: ch = 7'h64; // d
            8'h21: ch = 7'h66; // f
            8'h22: ch = 7'h67; // g
            8'h23: ch = 7'h68; // h
            8'h24: ch = 7'h6A; // j
            8'h25: ch = 7'h6B; // k
            8'h26: ch = 7'h6C; // l
            8'h2C: ch = 7'h79; // y
            8'h2D: ch = 7'h78; // x
            8'h2E: ch = 7'h63; // c
            8'h2F: ch = 7'h76; // v
            8'h30: ch = 7'h62; // b
            8'h31: ch = 7'h6E; // n
            8'h32: ch = 7'h6D; // m
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/scta_ring.sv -----
`timescale 1ns / 1ps

module scta_ring
    import scta_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_mem,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CHAR_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [CHAR_W-1:0] o_rdata
);

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; hold the data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_mem.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/scta_ctrl.sv -----
`timescale 1ns / 1ps

module scta_ctrl
    import scta_pkg::*;
#(
    parameter int DEPTH    = QUEUE_DEPTH_DEF,
    parameter int MAX_READ = MAX_READ_DEF,
    parameter int AW       = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_data,
    output t_mem_ctl          o_mem,
    output logic [AW-1:0]     o_waddr,
    output logic [CHAR_W-1:0] o_wdata,
    output logic [AW-1:0]     o_raddr,
    input  logic [CHAR_W-1:0] i_rdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]      r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [COUNT_W-1:0] r_left, n_left;
    logic               r_vld, n_vld;
    logic               r_chv, n_chv;
    logic               r_last, n_last;
    logic               r_ovf_out, n_ovf_out;

    logic               in_acc;
    logic               slot_free;
    logic [CHAR_W-1:0]  ch;
    logic [COUNT_W-1:0] want_sat;
    logic [COUNT_W-1:0] take_n;
    logic               full;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_vld || i_out_ready;
    assign ch         = scta_translate(i_in_data.scan_code);
    assign full       = (r_count == CW'(DEPTH));

    // Clamp the request, then to what is stored
    always_comb begin
        want_sat = (i_in_data.read_count > COUNT_W'(MAX_READ)) ?
                   COUNT_W'(MAX_READ) : i_in_data.read_count;
        take_n   = (NW'(want_sat) < NW'(r_count)) ? want_sat : COUNT_W'(r_count);
    end

    always_comb begin
        n_state   = r_state;
        n_wr_ptr  = r_wr_ptr;
        n_rd_ptr  = r_rd_ptr;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_left    = r_left;
        n_vld     = r_vld && !i_out_ready;
        n_chv     = r_chv;
        n_last    = r_last;
        n_ovf_out = r_ovf_out;
        o_mem     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.cmd == CMD_SCAN) && (ch != '0)) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        o_mem.wr_en = 1'b1;
                        n_wr_ptr    = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
                        n_count     = r_count + 1'b1;
                    end
                end else if (in_acc && (i_in_data.cmd == CMD_READ)) begin
                    n_count = r_count - CW'(take_n);
                    n_left  = take_n;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (slot_free) begin
                    n_vld     = 1'b1;
                    n_ovf_out = r_ovf;
                    if (r_left != '0) begin
                        o_mem.rd_en = 1'b1;
                        n_rd_ptr    = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
                        n_left      = r_left - 1'b1;
                        n_chv       = 1'b1;
                        n_last      = (r_left == COUNT_W'(1));
                        if (r_left == COUNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        // empty read
                        n_chv   = 1'b0;
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_left   <= '0;
            r_vld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_left    <= n_left;
            r_vld     <= n_vld;
            r_chv     <= n_chv;
            r_last    <= n_last;
            r_ovf_out <= n_ovf_out;
        end
    end

    assign o_waddr = r_wr_ptr;
    assign o_wdata = ch;
    assign o_raddr = r_rd_ptr;

    assign o_out_valid                = r_vld;
    assign o_out_data.char_code       = r_chv ? i_rdata : '0;
    assign o_out_data.char_valid      = r_chv;
    assign o_out_data.last            = r_last;
    assign o_out_data.overflow_seen   = r_ovf_out;

endmodule

// ----- rtl/core/scancode_to_ascii_fifo.sv -----
`timescale 1ns / 1ps

// Keyboard scan code (set 1, QWERTZ) to ASCII translator with a ring queue.
// Input channel (i_in_valid / o_in_ready / i_in_data): each word is either
// a scan code (cmd = scan) or a read request (cmd = read, read_count chars).
// A scan code is translated and written into the ring store in the same
// cycle that it is accepted; codes with no character are dropped, and a character
// that meets a full queue is dropped and sets the sticky overflow flag.
// Once a read request is accepted, the controller issues one ring-store read
// per cycle unless the output stalls; each character appears on the output
// in the cycle after its read, one word per cycle while the receiver takes
// them. An empty read returns a single word with char_valid low and last
// high. The input is held off (o_in_ready low) while a read is still
// issuing; the single ring-store read port sets that rate.
// Output channel (o_out_valid / i_out_ready / o_out_data): when the receiver
// stalls, hold the word and issue no further read; the store's read register
// doubles as the output register. Scan codes are still taken while the final
// word of a read waits.
// Reset (synchronous, active low) empties the queue and clears the flag; the
// store contents are not cleared and no clearing pass is needed.
module scancode_to_ascii_fifo
    import scta_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_READ    = MAX_READ_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [CHAR_W-1:0] wdata;
    logic [CHAR_W-1:0] rdata;

    // Pointers, fill count, overflow flag and read sequencing
    scta_ctrl #(
        .DEPTH    (QUEUE_DEPTH),
        .MAX_READ (MAX_READ),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_mem       (mem_ctl),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    // Character store: one write and one registered read per cycle. A write
    // and a read never meet on one entry in a cycle, as input is held off
    // while reads issue.
    scta_ring #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_mem   (mem_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

// ----- rtl/core/scta_check.sv -----
`timescale 1ns / 1ps

module scta_check
    import scta_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_data
);

    // Output is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // An empty read word is a single, final word with no character
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.char_valid) |->
            (o_out_data.last && (o_out_data.char_code == '0)))
        else $error("empty read word malformed");

    // No new word is taken while a read still has words to deliver
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> !o_in_ready)
        else $error("input taken during a read");

    // Hold a stalled output word
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output word changed");

endmodule

bind scancode_to_ascii_fifo scta_check u_scta_check (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import scta_pkg::*;

    // Set-1 scan codes that the translation cares about
    localparam logic [CODE_W-1:0] SC_NONE      = 8'h00;
    localparam logic [CODE_W-1:0] SC_ONE       = 8'h02;
    localparam logic [CODE_W-1:0] SC_NINE      = 8'h0A;
    localparam logic [CODE_W-1:0] SC_BKSP      = 8'h0E;
    localparam logic [CODE_W-1:0] SC_Q         = 8'h10;
    localparam logic [CODE_W-1:0] SC_P         = 8'h19;
    localparam logic [CODE_W-1:0] SC_UMLAUT_U  = 8'h1A;
    localparam logic [CODE_W-1:0] SC_PLUS      = 8'h1B;
    localparam logic [CODE_W-1:0] SC_ENTER     = 8'h1C;
    localparam logic [CODE_W-1:0] SC_A         = 8'h1E;
    localparam logic [CODE_W-1:0] SC_L         = 8'h26;
    localparam logic [CODE_W-1:0] SC_ZERO      = 8'h29;
    localparam logic [CODE_W-1:0] SC_Y         = 8'h2C;
    localparam logic [CODE_W-1:0] SC_M         = 8'h32;
    localparam logic [CODE_W-1:0] SC_SPACE     = 8'h39;
    localparam logic [CODE_W-1:0] SC_DOT_REL   = 8'hB4;
    localparam logic [CODE_W-1:0] SC_SLASH_REL = 8'hB5;
    localparam logic [CODE_W-1:0] SC_ALL_ONES  = 8'hFF;

    localparam int IDLE_PCT    = 12;
    localparam int CHOKE_LEN   = 300;
    localparam int DRAIN_WAIT  = 20;
    localparam int RANDOM_KEYS = 24;

    // One word waiting to go in, plus how the sender should treat it
    typedef struct {
        t_in_word word;
        bit       hold;   // wait until every expected character has come out
        bit       choke;  // ask the receiver for a long hold-off
        bit       calm;   // no idling on either side while this word is current
    } t_key_job;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;

    t_key_job  keys_to_send[$];
    t_out_word chars_due[$];

    // Shadow of the queue inside the block
    logic [CHAR_W-1:0] shadow_ring [QUEUE_DEPTH_DEF];
    int                head_idx;
    int                tail_idx;
    int                held_chars;
    logic              chars_dropped;

    logic [CODE_W-1:0] typeable[$];

    int   errors       = 0;
    int   words_taken  = 0;
    int   words_total  = 0;
    int   fill_plan    = 0;
    logic took_word    = 1'b0;
    int   gap_left     = 0;
    logic calm_now     = 1'b0;
    int   choke_reqs   = 0;
    int   choke_seen   = 0;
    int   stall_left   = 0;

    scancode_to_ascii_fifo u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // QWERTZ layout, set 1; zero means the key gives no character
    function automatic logic [CHAR_W-1:0] char_of(logic [CODE_W-1:0] code);
        string digits = "123456789";
        string row_q  = "qwertzuiop";
        string row_a  = "asdfghjkl";
        string row_y  = "yxcvbnm";
        if (code == SC_ENTER)     return 7'h0A;   // line feed
        if (code == SC_SPACE)     return 7'h20;
        if (code == SC_BKSP)      return 7'h0D;   // carriage return
        if (code == SC_DOT_REL)   return 7'h2E;
        if (code == SC_SLASH_REL) return 7'h2F;
        if (code == SC_ZERO)      return 7'h30;
        if (code >= SC_ONE && code <= SC_NINE) return CHAR_W'(digits[int'(code - SC_ONE)]);
        if (code >= SC_Q && code <= SC_P)      return CHAR_W'(row_q[int'(code - SC_Q)]);
        if (code >= SC_A && code <= SC_L)      return CHAR_W'(row_a[int'(code - SC_A)]);
        if (code >= SC_Y && code <= SC_M)      return CHAR_W'(row_y[int'(code - SC_Y)]);
        return '0;
    endfunction

    // Advance the shadow queue by one accepted word and queue what must come out
    task automatic type_or_read(t_in_word w);
        logic [CHAR_W-1:0] ch;
        int                want;
        int                n;
        if (w.cmd == CMD_SCAN) begin
            ch = char_of(w.scan_code);
            if (ch != '0) begin
                if (held_chars >= QUEUE_DEPTH_DEF) begin
                    chars_dropped = 1'b1;
                end else begin
                    shadow_ring[tail_idx] = ch;
                    tail_idx   = (tail_idx + 1) % QUEUE_DEPTH_DEF;
                    held_chars = held_chars + 1;
                end
            end
        end else begin
            want = (int'(w.read_count) > MAX_READ_DEF) ? MAX_READ_DEF : int'(w.read_count);
            n    = (want < held_chars) ? want : held_chars;
            if (n == 0) begin
                chars_due.push_back('{char_code: '0, char_valid: 1'b0, last: 1'b1,
                                      overflow_seen: chars_dropped});
            end
            for (int k = 0; k < n; k++) begin
                chars_due.push_back('{char_code: shadow_ring[head_idx], char_valid: 1'b1,
                                      last: (k == n - 1), overflow_seen: chars_dropped});
                head_idx = (head_idx + 1) % QUEUE_DEPTH_DEF;
            end
            held_chars = held_chars - n;
        end
    endtask

    task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    function automatic t_in_word scan_word(logic [CODE_W-1:0] code);
        t_in_word w;
        w.cmd        = CMD_SCAN;
        w.scan_code  = code;
        w.read_count = COUNT_W'($urandom_range(2**COUNT_W - 1));  // unused, toggle anyway
        return w;
    endfunction

    function automatic t_in_word read_word(int n);
        t_in_word w;
        w.cmd        = CMD_READ;
        w.scan_code  = CODE_W'($urandom_range(2**CODE_W - 1));    // unused, toggle anyway
        w.read_count = COUNT_W'(n);
        return w;
    endfunction

    // Queue a word and track how full the block will be once it has gone in
    task automatic add(t_in_word w, bit hold = 1'b0, bit choke = 1'b0, bit calm = 1'b0);
        int want;
        keys_to_send.push_back('{word: w, hold: hold, choke: choke, calm: calm});
        words_total++;
        if (w.cmd == CMD_SCAN) begin
            if (char_of(w.scan_code) != '0 && fill_plan < QUEUE_DEPTH_DEF) fill_plan++;
        end else begin
            want = (int'(w.read_count) > MAX_READ_DEF) ? MAX_READ_DEF : int'(w.read_count);
            fill_plan = fill_plan - ((want < fill_plan) ? want : fill_plan);
        end
    endtask

    function automatic logic [CODE_W-1:0] any_typeable();
        return typeable[$urandom_range(typeable.size() - 1)];
    endfunction

    // Sender: present a new word once the last one has gone; hold it until taken.
    // Hold off on words flagged to wait until the output has caught up.
    always @(negedge i_clk) begin
        t_key_job job;
        if (i_rst_n && (!i_in_valid || took_word)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (keys_to_send.size() > 0 &&
                         !(keys_to_send[0].hold && chars_due.size() > 0)) begin
                if (!keys_to_send[0].calm && $urandom_range(99) < IDLE_PCT) begin
                    gap_left = $urandom_range(2);
                    i_in_valid <= 1'b0;
                end else begin
                    job = keys_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_data  <= job.word;
                    calm_now   <= job.calm;
                    if (job.choke) choke_reqs <= choke_reqs + 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, a long hold-off on request, none when calm
    always @(negedge i_clk) begin
        if (choke_seen != choke_reqs) begin
            choke_seen = choke_reqs;
            stall_left = CHOKE_LEN;
        end
        if (stall_left > 0) begin
            stall_left  = stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm_now || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: check each word leaving, then predict from each word entering
    always @(posedge i_clk) begin
        t_out_word want;
        took_word <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (chars_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got %h", $time, o_out_data);
                end else begin
                    want = chars_due.pop_front();
                    check_field("char_code", 8'(want.char_code), 8'(o_out_data.char_code));
                    check_field("char_valid", 8'(want.char_valid), 8'(o_out_data.char_valid));
                    check_field("last", 8'(want.last), 8'(o_out_data.last));
                    check_field("overflow_seen", 8'(want.overflow_seen),
                                8'(o_out_data.overflow_seen));
                end
            end
            if (i_in_valid && o_in_ready) begin
                type_or_read(i_in_data);
                words_taken++;
            end
        end
    end

    initial begin
        logic [CODE_W-1:0] probe[] = '{SC_NONE, SC_UMLAUT_U, SC_PLUS, SC_ALL_ONES,
                                       SC_DOT_REL, SC_SLASH_REL, SC_ENTER, SC_SPACE,
                                       SC_BKSP, SC_ZERO, SC_ONE, SC_NINE, SC_Q, SC_P,
                                       SC_A, SC_L, SC_Y, SC_M};
        int made;
        int burst;
        int reads;
        bit first;

        head_idx      = 0;
        tail_idx      = 0;
        held_chars    = 0;
        chars_dropped = 1'b0;
        for (int c = 0; c < 2**CODE_W; c++) begin
            if (char_of(CODE_W'(c)) != '0) typeable.push_back(CODE_W'(c));
        end

        // Directed: empty reads, keys that give nothing, every kind of key,
        // a zero-count read with data held, then saturation past the read limit
        add(read_word(0));
        add(read_word(5));
        foreach (probe[i]) add(scan_word(probe[i]));
        add(read_word(0));
        add(read_word(3));
        add(read_word(2**COUNT_W - 1));
        add(read_word(MAX_READ_DEF));

        // Long receiver hold-off while reads pile up behind the output
        add(scan_word(any_typeable()), 1'b1, 1'b1);
        for (int i = 0; i < 29; i++) add(scan_word(any_typeable()));
        for (int i = 0; i < 2; i++)  add(read_word(5));

        // Random: bursts of typing followed by reads, a calm stretch in the middle
        made  = 0;
        first = 1'b1;
        while (made < RANDOM_KEYS) begin
            burst = $urandom_range(12, 1);
            for (int i = 0; i < burst; i++) begin
                add(scan_word(($urandom_range(99) < 85) ? any_typeable()
                                                         : CODE_W'($urandom_range(255))),
                    first || (i == 0 && $urandom_range(99) < 8), 1'b0,
                    made >= 8 && made < 16);
                first = 1'b0;
                made++;
            end
            reads = $urandom_range(2, 1);
            for (int i = 0; i < reads; i++) begin
                add(read_word(($urandom_range(99) < 80) ? $urandom_range(burst + 2)
                                                         : $urandom_range(MAX_READ_DEF)),
                    1'b0, 1'b0, made >= 8 && made < 16);
                made++;
            end
        end

        // Fill the queue to the brim with no idling, then overfill: drop characters,
        // set the sticky flag, wrap the pointers
        add(scan_word(any_typeable()), 1'b1, 1'b0, 1'b1);
        while (fill_plan < QUEUE_DEPTH_DEF) add(scan_word(any_typeable()), 1'b0, 1'b0, 1'b1);
        for (int i = 0; i < 4; i++) add(scan_word(any_typeable()));
        for (int i = 0; i < QUEUE_DEPTH_DEF / MAX_READ_DEF + 1; i++) add(read_word(MAX_READ_DEF));
        for (int i = 0; i < 3; i++) add(scan_word(any_typeable()));
        add(read_word(2));
        add(read_word(MAX_READ_DEF));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (words_taken < words_total || chars_due.size() > 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- scancode_to_ascii_fifo.f -----
rtl/core/scta_pkg.sv
rtl/core/scta_ring.sv
rtl/core/scta_ctrl.sv
rtl/core/scancode_to_ascii_fifo.sv
rtl/core/scta_check.sv
dv/tb.sv
